// ===== rtl/uer_pkg.sv =====
// Shared types and constants for the ultrasonic echo ranger.
`timescale 1ns / 1ps

package uer_pkg;

    localparam int unsigned TRIG_W    = 8;
    localparam int unsigned TIMEOUT_W = 16;
    localparam int unsigned GLITCH_W  = 6;
    localparam int unsigned TRAVEL_W  = 16;
    localparam int unsigned DIST_W    = 11;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLITCH  = 2'd2;

    localparam logic [TRIG_W-1:0]    TRIGGER_RST = 8'd20;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd19140;
    localparam logic [GLITCH_W-1:0]  GLITCH_RST  = 6'd30;

    typedef struct packed {
        logic [TRIG_W-1:0]    trigger_ticks;
        logic [TIMEOUT_W-1:0] timeout_ticks;
        logic [GLITCH_W-1:0]  glitch_ticks;
    } cfg_t;

    typedef struct packed {
        logic [DIST_W-1:0]   distance_cm;
        logic [TRAVEL_W-1:0] travel_ticks;
        logic                timed_out;
        logic                done_res;
        logic                busy_res;
        logic                trigger;
    } res_t;

endpackage

// ===== rtl/uer_cfg_regs.sv =====
// Configuration register file for the echo ranger.
`timescale 1ns / 1ps

module uer_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output uer_pkg::cfg_t                   cfg
);
    import uer_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_TRIGGER: cfg_next.trigger_ticks = cfg_wdata[TRIG_W-1:0];
                CFG_TIMEOUT: cfg_next.timeout_ticks = cfg_wdata[TIMEOUT_W-1:0];
                CFG_GLITCH:  cfg_next.glitch_ticks  = cfg_wdata[GLITCH_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.trigger_ticks <= TRIGGER_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_RST;
            cfg_reg.glitch_ticks  <= GLITCH_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/uer_ctrl.sv =====
// Ranging sequencer: trigger pulse, echo timing and distance conversion per tick.
`timescale 1ns / 1ps

module uer_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step_en,
    input  logic          start_req,
    input  logic          echo,
    input  uer_pkg::cfg_t cfg,
    output uer_pkg::res_t res
);
    import uer_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TRIG = 2'd1;
    localparam logic [1:0] PH_WAIT = 2'd2;
    localparam logic [1:0] PH_MEAS = 2'd3;

    // floor(x / 58) = (x * ceil(2^22 / 58)) >> 22 for every 16-bit x
    localparam int unsigned DIV_SHIFT = 22;
    localparam int unsigned RECIP_W   = 17;
    localparam int unsigned PROD_W    = TRAVEL_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DIV58_RECIP = 17'd72316;

    logic [1:0]           phase_reg, phase_next;
    logic [TRAVEL_W-1:0]  elapsed_reg, elapsed_next;
    logic [TRAVEL_W-1:0]  last_high_reg, last_high_next;
    logic [GLITCH_W-1:0]  low_run_reg, low_run_next;
    logic [TRIG_W-1:0]    pulse_reg, pulse_next;

    logic [TRIG_W-1:0]    trig_len;
    logic [TRAVEL_W-1:0]  elapsed_inc;
    logic [TRAVEL_W-1:0]  travel;
    logic [PROD_W-1:0]    prod;
    logic                 trig;
    logic                 done;
    logic                 tmo;

    assign trig_len    = (cfg.trigger_ticks == '0) ? TRIG_W'(1) : cfg.trigger_ticks;
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + TRAVEL_W'(1);

    always_comb begin
        phase_next     = phase_reg;
        elapsed_next   = elapsed_reg;
        last_high_next = last_high_reg;
        low_run_next   = low_run_reg;
        pulse_next     = pulse_reg;
        trig           = 1'b0;
        done           = 1'b0;
        tmo            = 1'b0;
        travel         = '0;
        case (phase_reg)
            PH_IDLE: begin
                if (start_req) begin
                    trig       = 1'b1;
                    pulse_next = TRIG_W'(1);
                    phase_next = (TRIG_W'(1) >= trig_len) ? PH_WAIT : PH_TRIG;
                end
            end
            PH_TRIG: begin
                trig       = 1'b1;
                pulse_next = pulse_reg + TRIG_W'(1);
                if (pulse_next >= trig_len) begin
                    phase_next = PH_WAIT;
                end
            end
            PH_WAIT: begin
                if (echo) begin
                    elapsed_next   = '0;
                    last_high_next = '0;
                    low_run_next   = '0;
                    phase_next     = PH_MEAS;
                    if (cfg.timeout_ticks == '0) begin
                        done       = 1'b1;
                        tmo        = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_MEAS: begin
                elapsed_next = elapsed_inc;
                if (echo) begin
                    low_run_next   = '0;
                    last_high_next = elapsed_inc;
                    if (elapsed_inc >= cfg.timeout_ticks) begin
                        done       = 1'b1;
                        tmo        = 1'b1;
                        travel     = elapsed_inc;
                        phase_next = PH_IDLE;
                    end
                end else if (low_run_reg >= cfg.glitch_ticks) begin
                    done       = 1'b1;
                    travel     = last_high_reg;
                    phase_next = PH_IDLE;
                end else begin
                    low_run_next = low_run_reg + GLITCH_W'(1);
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    assign prod = PROD_W'(travel) * PROD_W'(DIV58_RECIP);

    always_comb begin
        res.trigger      = trig;
        res.busy_res     = (phase_next != PH_IDLE);
        res.done_res     = done;
        res.timed_out    = tmo;
        res.travel_ticks = travel;
        res.distance_cm  = prod[DIV_SHIFT +: DIST_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            elapsed_reg   <= '0;
            last_high_reg <= '0;
            low_run_reg   <= '0;
            pulse_reg     <= '0;
        end else if (step_en) begin
            phase_reg     <= phase_next;
            elapsed_reg   <= elapsed_next;
            last_high_reg <= last_high_next;
            low_run_reg   <= low_run_next;
            pulse_reg     <= pulse_next;
        end
    end

endmodule

// ===== rtl/ultrasonic_echo_ranger_top.sv =====
// Top level of the ultrasonic echo ranger: stream ports, beat registers, assertions.
// An accepted input beat goes through the input register, the sequencer step, then the
// result register. Throughput: one beat per cycle while m_axis_tready does not stall the
// output. Reset (aresetn low, synchronous) empties both beat registers, returns the
// sequencer to idle and loads the register defaults.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [0] start_req, [1] echo, [7:2] zero
    input  logic [uer_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] trigger, [1] busy_res, [2] done_res, [3] timed_out,
    // [19:4] travel_ticks, [30:20] distance_cm, [31] zero
    output logic [uer_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  logic                            cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import uer_pkg::*;

    cfg_t cfg;
    res_t res;
    res_t res_reg;

    logic in_valid_reg;
    logic start_reg;
    logic echo_reg;
    logic out_valid_reg;
    logic advance;
    logic step_en;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step_en       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    uer_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    uer_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .start_req (start_reg),
        .echo      (echo_reg),
        .cfg       (cfg),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            start_reg <= s_axis_tdata[0];
            echo_reg  <= s_axis_tdata[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, res_reg.distance_cm, res_reg.travel_ticks,
                            res_reg.timed_out, res_reg.done_res,
                            res_reg.busy_res, res_reg.trigger};

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && res_reg.done_res |-> !res_reg.busy_res)
        else $error("done beat still reports busy");

    a_timeout_with_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && res_reg.timed_out |-> res_reg.done_res)
        else $error("timeout flagged without done");

    a_idle_payload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !res_reg.done_res |->
            res_reg.travel_ticks == '0 && res_reg.distance_cm == '0)
        else $error("travel reported without done");

    a_stall_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(res_reg) && m_axis_tvalid)
        else $error("result beat changed under stall");

endmodule

// ===== dv/tb_ultrasonic_echo_ranger_top.sv =====
// Self-checking testbench for the ultrasonic echo ranger: directed and random tick streams checked per beat.
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranger_top;

    import uer_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED     = 2'd3;
    localparam logic [TRAVEL_W-1:0]  TICKS_PER_CM   = 16'd58;
    localparam int unsigned          RX_HOLD_CYCLES = 80;
    localparam int unsigned          PHASE_TICKS    = 200;
    localparam longint unsigned      RUN_LIMIT_NS   = 64'd24_000_000;

    typedef enum logic [1:0] {RG_IDLE, RG_TRIG, RG_WAIT, RG_MEAS} ranger_phase_t;

    typedef struct packed {
        logic start_req;
        logic echo;
    } tick_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

    ultrasonic_echo_ranger_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // ranging predictor state
    cfg_t                ranger_cfg   = '{TRIGGER_RST, TIMEOUT_RST, GLITCH_RST};
    ranger_phase_t       ranger_phase = RG_IDLE;
    logic [TRAVEL_W-1:0] echo_elapsed = '0;
    logic [TRAVEL_W-1:0] last_high_at = '0;
    logic [GLITCH_W-1:0] low_spell    = '0;
    logic [TRIG_W-1:0]   trig_driven  = '0;

    tick_t       pending_ticks[$];
    res_t        ranging_expected[$];
    tick_t       offered_tick;
    res_t        seen;
    res_t        wanted;
    int unsigned mismatches  = 0;
    int unsigned beats_seen  = 0;
    int unsigned phase_items = 0;
    int unsigned hold_asks   = 0;
    int unsigned hold_seen   = 0;
    int unsigned hold_left   = 0;
    bit          steady      = 1'b0;

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    function automatic res_t ranger_tick(input tick_t t);
        res_t              r;
        logic [TRIG_W-1:0] trig_len;
        r = '0;
        trig_len = (ranger_cfg.trigger_ticks == '0) ? 8'd1 : ranger_cfg.trigger_ticks;
        case (ranger_phase)
            RG_IDLE: begin
                if (t.start_req) begin
                    r.trigger = 1'b1;
                    trig_driven = 8'd1;
                    ranger_phase = (trig_driven >= trig_len) ? RG_WAIT : RG_TRIG;
                end
            end
            RG_TRIG: begin
                r.trigger = 1'b1;
                trig_driven = trig_driven + 8'd1;
                if (trig_driven >= trig_len) ranger_phase = RG_WAIT;
            end
            RG_WAIT: begin
                if (t.echo) begin
                    echo_elapsed = '0;
                    last_high_at = '0;
                    low_spell = '0;
                    ranger_phase = RG_MEAS;
                    if (ranger_cfg.timeout_ticks == '0) begin
                        r.done_res = 1'b1;
                        r.timed_out = 1'b1;
                        ranger_phase = RG_IDLE;
                    end
                end
            end
            default: begin
                if (echo_elapsed != 16'hFFFF) echo_elapsed = echo_elapsed + 16'd1;
                if (t.echo) begin
                    low_spell = '0;
                    last_high_at = echo_elapsed;
                    if (echo_elapsed >= ranger_cfg.timeout_ticks) begin
                        r.done_res = 1'b1;
                        r.timed_out = 1'b1;
                        r.travel_ticks = echo_elapsed;
                        ranger_phase = RG_IDLE;
                    end
                end else if (low_spell >= ranger_cfg.glitch_ticks) begin
                    r.done_res = 1'b1;
                    r.travel_ticks = last_high_at;
                    ranger_phase = RG_IDLE;
                end else begin
                    low_spell = low_spell + 6'd1;
                end
            end
        endcase
        r.busy_res = (ranger_phase != RG_IDLE);
        r.distance_cm = DIST_W'(r.travel_ticks / TICKS_PER_CM);
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatches < 200)
            $display("beat %0d: %s got 0x%0h expected 0x%0h", beats_seen, what, got, want);
        mismatches++;
    endtask

    task automatic push_tick(input logic start_req, input logic echo);
        pending_ticks.push_back('{start_req: start_req, echo: echo});
        phase_items++;
    endtask

    task automatic drain();
        do @(negedge aclk);
        while (pending_ticks.size() != 0 || s_axis_tvalid || ranging_expected.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_TRIGGER: ranger_cfg.trigger_ticks = value[TRIG_W-1:0];
            CFG_TIMEOUT: ranger_cfg.timeout_ticks = value[TIMEOUT_W-1:0];
            CFG_GLITCH:  ranger_cfg.glitch_ticks  = value[GLITCH_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // one start, trigger, wait and echo body; busy-time starts and noise are random
    task automatic push_measurement();
        int unsigned trig_len;
        int unsigned gl;
        int unsigned tmo;
        int unsigned el;
        int unsigned l;
        int unsigned h;
        trig_len = (ranger_cfg.trigger_ticks == '0) ? 32'd1 : 32'(ranger_cfg.trigger_ticks);
        gl  = 32'(ranger_cfg.glitch_ticks);
        tmo = 32'(ranger_cfg.timeout_ticks);
        repeat ($urandom_range(0, 2)) push_tick(1'b0, 1'($urandom));
        push_tick(1'b1, 1'($urandom));
        repeat (trig_len - 1) push_tick(1'($urandom), 1'($urandom));
        repeat ($urandom_range(0, 4)) push_tick(1'($urandom), 1'b0);
        push_tick(1'($urandom), 1'b1);
        el = 0;
        repeat ($urandom_range(0, 4)) begin
            l = ($urandom_range(0, 3) == 0) ? gl : $urandom_range(0, gl);
            repeat (l) push_tick(1'($urandom), 1'b0);
            h = $urandom_range(1, 6);
            repeat (h) push_tick(1'($urandom), 1'b1);
            el += l + h;
        end
        if (tmo > el && tmo - el <= 300 && $urandom_range(0, 3) == 0)
            repeat (tmo - el) push_tick(1'($urandom), 1'b1);
        else
            repeat (gl + 1) push_tick(1'($urandom), 1'b0);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                ranging_expected.push_back(ranger_tick(offered_tick));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_ticks.size() != 0 && (steady || $urandom_range(0, 99) >= 36)) begin
                    offered_tick = pending_ticks.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {6'b0, offered_tick.echo, offered_tick.start_req};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                beats_seen++;
                seen = m_axis_tdata[30:0];
                if (ranging_expected.size() == 0) begin
                    note_mismatch("beat with nothing pending", m_axis_tdata, '0);
                end else begin
                    wanted = ranging_expected.pop_front();
                    if (seen.trigger != wanted.trigger)
                        note_mismatch("trigger", 32'(seen.trigger), 32'(wanted.trigger));
                    if (seen.busy_res != wanted.busy_res)
                        note_mismatch("busy_res", 32'(seen.busy_res), 32'(wanted.busy_res));
                    if (seen.done_res != wanted.done_res)
                        note_mismatch("done_res", 32'(seen.done_res), 32'(wanted.done_res));
                    if (seen.timed_out != wanted.timed_out)
                        note_mismatch("timed_out", 32'(seen.timed_out), 32'(wanted.timed_out));
                    if (seen.travel_ticks != wanted.travel_ticks)
                        note_mismatch("travel_ticks", 32'(seen.travel_ticks),
                                      32'(wanted.travel_ticks));
                    if (seen.distance_cm != wanted.distance_cm)
                        note_mismatch("distance_cm", 32'(seen.distance_cm),
                                      32'(wanted.distance_cm));
                    if (m_axis_tdata[31])
                        note_mismatch("pad bit", 32'd1, 32'd0);
                end
            end
            if (hold_seen != hold_asks) begin
                hold_seen     <= hold_asks;
                hold_left     <= RX_HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= steady || ($urandom_range(0, 99) >= 36);
            end
        end
    end

    initial begin
        logic [TRIG_W-1:0]    trig;
        logic [TIMEOUT_W-1:0] tmo;
        logic [GLITCH_W-1:0]  gl;
        int unsigned          k;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // echo dropping at once, glitch resume, timeout at the limit, start while busy
        write_reg(CFG_TRIGGER, 16'hA502);
        write_reg(CFG_TIMEOUT, 16'd5);
        write_reg(CFG_GLITCH, 16'hFFC1);
        write_reg(CFG_UNUSED, 16'hFFFF);
        push_tick(1'b1, 1'b1);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b0);
        drain();

        // zero trigger length and zero timeout
        write_reg(CFG_TRIGGER, 16'd0);
        write_reg(CFG_TIMEOUT, 16'd0);
        write_reg(CFG_GLITCH, 16'd63);
        push_tick(1'b1, 1'b1);
        push_tick(1'b1, 1'b1);
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b1);

        for (k = 0; k < 6; k++) begin
            drain();
            case (k)
                0: begin
                    trig = 8'd1;
                    tmo  = 16'd1;
                    gl   = 6'd0;
                end
                1: begin
                    trig = 8'd255;
                    tmo  = 16'hFFFF;
                    gl   = 6'd63;
                end
                default: begin
                    trig = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(13, 60))
                                                       : 8'($urandom_range(0, 12));
                    case ($urandom_range(0, 2))
                        0: tmo = 16'($urandom_range(0, 30));
                        1: tmo = 16'($urandom_range(31, 500));
                        default: tmo = 16'($urandom);
                    endcase
                    gl = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 8)) : 6'($urandom);
                end
            endcase
            write_reg(CFG_TRIGGER, {8'($urandom), trig});
            write_reg(CFG_TIMEOUT, tmo);
            write_reg(CFG_GLITCH, {10'($urandom), gl});
            write_reg(CFG_UNUSED, 16'($urandom));
            steady = (k == 3);
            phase_items = 0;
            while (phase_items < PHASE_TICKS / 2) push_measurement();
            if (k == 2) begin
                // hold the result side while ticks keep coming, then let everything settle
                hold_asks++;
                drain();
            end
            while (phase_items < PHASE_TICKS) push_measurement();
        end

        // long high spell, short low gap, then end on timeout
        drain();
        write_reg(CFG_TRIGGER, 16'd1);
        write_reg(CFG_TIMEOUT, 16'd120);
        write_reg(CFG_GLITCH, 16'd63);
        steady = 1'b1;
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b1);
        repeat (118) push_tick(1'b0, 1'b1);
        repeat (3) push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b0);

        drain();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
